@@ rtl/core/bsub_pkg.sv @@
`default_nettype none

package bsub_pkg;

    localparam int WORD_W = 9;
    localparam int BYTE_W = 8;
    localparam int DEV_W  = 16;
    localparam int CMD_W  = 3;
    localparam int LVL_W  = 6;
    localparam int CNT_W  = 32;

    localparam int RX_DEPTH_DEF = 64;
    localparam int TX_DEPTH_DEF = 64;

    localparam logic [CMD_W-1:0] CMD_HOST_WR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HOST_RD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PURGE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEV_STAT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEV_RESP  = 3'd4;

    localparam int DEV_R_BIT    = 15;
    localparam int DEV_T_BIT    = 14;
    localparam int DEV_SHDN_BIT = 12;

    localparam logic [DEV_W-1:0] SPI_WRDATA = 16'h8000;
    localparam logic [DEV_W-1:0] SPI_RDDATA = 16'h0000;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } bsub_state_t;

endpackage

`default_nettype wire

@@ rtl/core/bsub_if.sv @@
`default_nettype none

interface bsub_req_if;
    import bsub_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [WORD_W-1:0]   data_in;
    logic [DEV_W-1:0]    device_word;

    modport source (output valid, command, data_in, device_word, input ready);
    modport sink   (input valid, command, data_in, device_word, output ready);
endinterface

interface bsub_rsp_if;
    import bsub_pkg::*;

    logic                valid;
    logic                ready;
    logic                spi_valid;
    logic [DEV_W-1:0]    spi_word;
    logic                accepted;
    logic                read_valid;
    logic [WORD_W-1:0]   read_data;
    logic                parity_error;
    logic                service_done;
    logic [LVL_W-1:0]    read_level;
    logic [LVL_W-1:0]    write_space;
    logic [CNT_W-1:0]    overflow_count;
    logic [CNT_W-1:0]    parity_error_count;
    logic [CNT_W-1:0]    sent_count;

    modport source (
        output valid, spi_valid, spi_word, accepted, read_valid, read_data,
               parity_error, service_done, read_level, write_space,
               overflow_count, parity_error_count, sent_count,
        input  ready
    );
    modport sink (
        input  valid, spi_valid, spi_word, accepted, read_valid, read_data,
               parity_error, service_done, read_level, write_space,
               overflow_count, parity_error_count, sent_count,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/bsub_ram.sv @@
`default_nettype none

module bsub_ram #(
    parameter int DEPTH = bsub_pkg::RX_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  wire logic [bsub_pkg::WORD_W-1:0]    wr_data,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic      [bsub_pkg::WORD_W-1:0]    rd_data
);
    import bsub_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bsub_core.sv @@
`default_nettype none

module bsub_core #(
    parameter int RX_DEPTH = bsub_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = bsub_pkg::TX_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_wdata,
    bsub_req_if.sink                               req,
    bsub_rsp_if.source                             rsp,
    output logic                                   rx_wr_en,
    output logic      [$clog2(RX_DEPTH)-1:0]       rx_wr_addr,
    output logic      [bsub_pkg::WORD_W-1:0]       rx_wr_data,
    output logic                                   rx_rd_en,
    output logic      [$clog2(RX_DEPTH)-1:0]       rx_rd_addr,
    input  wire logic [bsub_pkg::WORD_W-1:0]       rx_rd_data,
    output logic                                   tx_wr_en,
    output logic      [$clog2(TX_DEPTH)-1:0]       tx_wr_addr,
    output logic      [bsub_pkg::WORD_W-1:0]       tx_wr_data,
    output logic                                   tx_rd_en,
    output logic      [$clog2(TX_DEPTH)-1:0]       tx_rd_addr,
    input  wire logic [bsub_pkg::WORD_W-1:0]       tx_rd_data
);
    import bsub_pkg::*;

    localparam int RX_PW = $clog2(RX_DEPTH);
    localparam int TX_PW = $clog2(TX_DEPTH);
    localparam int RX_LW = (RX_PW + 1 > LVL_W) ? RX_PW + 1 : LVL_W;
    localparam int TX_LW = (TX_PW + 1 > LVL_W) ? TX_PW + 1 : LVL_W;

    bsub_state_t state_reg, state_next;

    logic                parity_auto_reg;
    logic [RX_PW-1:0]    rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_PW-1:0]    tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic                rop_reg, rop_next;
    logic [CNT_W-1:0]    ovf_reg, ovf_next, par_reg, par_next, sent_reg, sent_next;

    logic [CMD_W-1:0]    cmd_reg;
    logic [WORD_W-1:0]   din_reg;
    logic [DEV_W-1:0]    dev_reg;

    logic                out_valid_reg;
    logic                spi_valid_reg, spi_valid_next;
    logic [DEV_W-1:0]    spi_word_reg, spi_word_next;
    logic                accepted_reg, accepted_next;
    logic                read_valid_reg, read_valid_next;
    logic [WORD_W-1:0]   read_data_reg, read_data_next;
    logic                perr_reg, perr_next;
    logic                done_reg, done_next;
    logic [LVL_W-1:0]    level_reg, space_reg;

    logic                accept;
    logic                commit;
    logic [RX_PW-1:0]    rx_head_inc, rx_tail_inc;
    logic [TX_PW-1:0]    tx_head_inc, tx_tail_inc;
    logic [WORD_W-1:0]   tx_word;
    logic [RX_LW-1:0]    rx_lvl;
    logic [TX_LW-1:0]    tx_lvl, tx_space;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign commit    = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    assign rx_head_inc = (rx_head_reg == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_head_reg + 1'b1;
    assign rx_tail_inc = (rx_tail_reg == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_tail_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_tail_reg + 1'b1;

    assign tx_word = parity_auto_reg ? {^din_reg[BYTE_W-1:0], din_reg[BYTE_W-1:0]} : din_reg;

    assign rx_rd_en   = accept;
    assign rx_rd_addr = rx_tail_reg;
    assign tx_rd_en   = accept;
    assign tx_rd_addr = tx_tail_reg;

    assign rx_wr_addr = rx_head_reg;
    assign rx_wr_data = dev_reg[WORD_W-1:0];
    assign tx_wr_addr = tx_head_reg;
    assign tx_wr_data = tx_word;

    always_comb
    begin
        state_next      = state_reg;
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        rop_next        = rop_reg;
        ovf_next        = ovf_reg;
        par_next        = par_reg;
        sent_next       = sent_reg;
        spi_valid_next  = 1'b0;
        spi_word_next   = '0;
        accepted_next   = 1'b0;
        read_valid_next = 1'b0;
        read_data_next  = '0;
        perr_next       = 1'b0;
        done_next       = 1'b0;
        rx_wr_en        = 1'b0;
        tx_wr_en        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                    case (cmd_reg)
                        CMD_HOST_WR:
                        begin
                            if (tx_head_inc != tx_tail_reg)
                            begin
                                accepted_next = 1'b1;
                                if (dev_reg[DEV_T_BIT])
                                begin
                                    spi_valid_next = 1'b1;
                                    spi_word_next  = SPI_WRDATA | DEV_W'(tx_word);
                                    sent_next      = sent_reg + 1'b1;
                                    rop_next       = 1'b0;
                                end
                                else
                                begin
                                    tx_wr_en     = 1'b1;
                                    tx_head_next = tx_head_inc;
                                end
                            end
                        end
                        CMD_HOST_RD:
                        begin
                            if (rx_head_reg != rx_tail_reg)
                            begin
                                rx_tail_next    = rx_tail_inc;
                                read_valid_next = 1'b1;
                                read_data_next  = rx_rd_data;
                                if (parity_auto_reg)
                                begin
                                    read_data_next = {1'b0, rx_rd_data[BYTE_W-1:0]};
                                    if (rx_rd_data[BYTE_W] != ^rx_rd_data[BYTE_W-1:0])
                                    begin
                                        perr_next = 1'b1;
                                        par_next  = par_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        CMD_PURGE:
                        begin
                            rx_tail_next = rx_head_reg;
                        end
                        CMD_DEV_STAT:
                        begin
                            if (!dev_reg[DEV_R_BIT] && !dev_reg[DEV_T_BIT])
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                spi_valid_next = 1'b1;
                                if (!dev_reg[DEV_SHDN_BIT] && dev_reg[DEV_T_BIT]
                                    && (tx_head_reg != tx_tail_reg))
                                begin
                                    spi_word_next = SPI_WRDATA | DEV_W'(tx_rd_data);
                                    tx_tail_next  = tx_tail_inc;
                                    sent_next     = sent_reg + 1'b1;
                                    rop_next      = 1'b0;
                                end
                                else
                                begin
                                    spi_word_next = SPI_RDDATA;
                                    rop_next      = 1'b1;
                                end
                            end
                        end
                        CMD_DEV_RESP:
                        begin
                            if (dev_reg[DEV_R_BIT])
                            begin
                                if (rx_head_inc == rx_tail_reg)
                                begin
                                    ovf_next = ovf_reg + 1'b1;
                                end
                                else
                                begin
                                    rx_wr_en     = 1'b1;
                                    rx_head_next = rx_head_inc;
                                end
                            end
                            else if (rop_reg)
                            begin
                                done_next = 1'b1;
                            end
                            rop_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (RX_LW'(rx_head_next) >= RX_LW'(rx_tail_next))
        begin
            rx_lvl = RX_LW'(rx_head_next) - RX_LW'(rx_tail_next);
        end
        else
        begin
            rx_lvl = RX_LW'(rx_head_next) + RX_LW'(RX_DEPTH) - RX_LW'(rx_tail_next);
        end
        if (TX_LW'(tx_head_next) >= TX_LW'(tx_tail_next))
        begin
            tx_lvl = TX_LW'(tx_head_next) - TX_LW'(tx_tail_next);
        end
        else
        begin
            tx_lvl = TX_LW'(tx_head_next) + TX_LW'(TX_DEPTH) - TX_LW'(tx_tail_next);
        end
        tx_space = TX_LW'(TX_DEPTH - 1) - tx_lvl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            parity_auto_reg <= 1'b0;
            rx_head_reg     <= '0;
            rx_tail_reg     <= '0;
            tx_head_reg     <= '0;
            tx_tail_reg     <= '0;
            rop_reg         <= 1'b0;
            ovf_reg         <= '0;
            par_reg         <= '0;
            sent_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            rop_reg      <= rop_next;
            ovf_reg      <= ovf_next;
            par_reg      <= par_next;
            sent_reg     <= sent_next;
            if (cfg_we)
            begin
                parity_auto_reg <= cfg_wdata;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            din_reg <= req.data_in;
            dev_reg <= req.device_word;
        end
        if (commit)
        begin
            spi_valid_reg  <= spi_valid_next;
            spi_word_reg   <= spi_word_next;
            accepted_reg   <= accepted_next;
            read_valid_reg <= read_valid_next;
            read_data_reg  <= read_data_next;
            perr_reg       <= perr_next;
            done_reg       <= done_next;
            level_reg      <= rx_lvl[LVL_W-1:0];
            space_reg      <= tx_space[LVL_W-1:0];
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.spi_valid          = spi_valid_reg;
    assign rsp.spi_word           = spi_word_reg;
    assign rsp.accepted           = accepted_reg;
    assign rsp.read_valid         = read_valid_reg;
    assign rsp.read_data          = read_data_reg;
    assign rsp.parity_error       = perr_reg;
    assign rsp.service_done       = done_reg;
    assign rsp.read_level         = level_reg;
    assign rsp.write_space        = space_reg;
    assign rsp.overflow_count     = ovf_reg;
    assign rsp.parity_error_count = par_reg;
    assign rsp.sent_count         = sent_reg;

endmodule

`default_nettype wire

@@ rtl/core/buffered_spi_uart_bridge_top.sv @@
// Host-side bridge to an SPI UART with a receive ring and a transmit ring of 9-bit words.
// Each request on the req channel carries a command, a host data word and the last word
// returned by the device; each request produces exactly one response on the rsp channel.
// The response tells whether an SPI word must go to the device, carries host read data,
// parity and service status, rx level, tx free space and three wrapping 32-bit counters.
// parity_auto is written through cfg_we and cfg_wdata; the user must write it only while
// no request is in flight, as the block itself does not enforce this.
// A request is accepted in ST_IDLE and its response is registered when ST_EXEC commits;
// the block takes no new request until then. ST_EXEC is needed for the synchronous read
// of the ring memories, which share their pointers with the update that follows.
// Reset clears the pointers, the counters, the pending read flag and parity_auto; ring
// contents are not cleared and need no clearing pass.
// When the receiver stalls, a finished response waits in the output register and the
// next request is taken, but it holds in ST_EXEC until the output register frees up.
`default_nettype none

module buffered_spi_uart_bridge_top #(
    parameter int RX_DEPTH = bsub_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = bsub_pkg::TX_DEPTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_we,
    input  wire logic    cfg_wdata,
    bsub_req_if.sink     req,
    bsub_rsp_if.source   rsp
);
    import bsub_pkg::*;

    logic                        rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [$clog2(RX_DEPTH)-1:0] rx_wr_addr, rx_rd_addr;
    logic [$clog2(TX_DEPTH)-1:0] tx_wr_addr, tx_rd_addr;
    logic [WORD_W-1:0]           rx_wr_data, rx_rd_data, tx_wr_data, tx_rd_data;

    bsub_core #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req),
        .rsp        (rsp),
        .rx_wr_en   (rx_wr_en),
        .rx_wr_addr (rx_wr_addr),
        .rx_wr_data (rx_wr_data),
        .rx_rd_en   (rx_rd_en),
        .rx_rd_addr (rx_rd_addr),
        .rx_rd_data (rx_rd_data),
        .tx_wr_en   (tx_wr_en),
        .tx_wr_addr (tx_wr_addr),
        .tx_wr_data (tx_wr_data),
        .tx_rd_en   (tx_rd_en),
        .tx_rd_addr (tx_rd_addr),
        .tx_rd_data (tx_rd_data)
    );

    bsub_ram #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (rx_wr_data),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    bsub_ram #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (tx_wr_data),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

endmodule

`default_nettype wire
